// ----- rtl/core/pfkp_pkg.sv -----
// ----------------------------------------------------------------------------
// pfkp_pkg: shared types and constants of the flow key parser
// Parse phases, status codes, protocol numbers and the result record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pfkp_pkg;

    // Parse phase, one-hot
    typedef enum logic [5:0] {
        PH_ETH  = 6'b000001,
        PH_V4   = 6'b000010,
        PH_V6   = 6'b000100,
        PH_EXT  = 6'b001000,
        PH_L4   = 6'b010000,
        PH_DONE = 6'b100000
    } t_phase;

    // Result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_TRUNC  = 2'd1;
    localparam logic [1:0] ST_NOTIP  = 2'd2;
    localparam logic [1:0] ST_EXTLIM = 2'd3;

    // Frame layout
    localparam logic [15:0] ETH_HDR_LEN  = 16'd14;
    localparam logic [15:0] V4_L4_START  = 16'd34;
    localparam logic [15:0] V6_L4_START  = 16'd54;
    localparam logic [15:0] ETYPE_IPV4   = 16'h0800;
    localparam logic [15:0] ETYPE_IPV6   = 16'h86DD;
    localparam logic [16:0] V6_HDR_LEN   = 17'd40;

    // Protocol / next-header numbers
    localparam logic [7:0] NH_HOPOPT   = 8'd0;
    localparam logic [7:0] NH_TCP      = 8'd6;
    localparam logic [7:0] NH_UDP      = 8'd17;
    localparam logic [7:0] NH_ROUTING  = 8'd43;
    localparam logic [7:0] NH_FRAGMENT = 8'd44;
    localparam logic [7:0] NH_AH       = 8'd51;
    localparam logic [7:0] NH_DSTOPTS  = 8'd60;

    // Minimum transport bytes and fragment header length
    localparam logic [15:0] TCP_HDR_LEN = 16'd20;
    localparam logic [15:0] UDP_HDR_LEN = 16'd8;
    localparam logic [11:0] FRAG_LEN    = 12'd8;

    // One parsed flow key
    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] src_address;
        logic [31:0] dst_address;
        logic [7:0]  protocol;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [16:0] packet_length;
        logic [7:0]  tcp_flag_bits;
        logic [15:0] l4_offset;
    } t_result;

    // Extension headers that the walk skips
    function automatic logic is_ext(input logic [7:0] nh);
        is_ext = (nh == NH_HOPOPT) || (nh == NH_ROUTING) || (nh == NH_FRAGMENT) ||
                 (nh == NH_AH) || (nh == NH_DSTOPTS);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/pfkp_parser.sv -----
// ----------------------------------------------------------------------------
// pfkp_parser: per-byte header walk
// Holds the parse state, advances it on every accepted byte and forms the
// flow key from the updated state when the byte closes the frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pfkp_parser #(
    parameter int MAX_EXT_HEADERS = 8
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_accept,
    input  wire  [7:0]            i_data_byte,
    input  wire                   i_last_byte,
    input  wire                   i_ext_walk,
    output pfkp_pkg::t_result     o_result
);

    localparam int CW = $clog2(MAX_EXT_HEADERS + 1);
    localparam logic [CW-1:0] EXT_MAX = CW'(MAX_EXT_HEADERS);

    // Parse state
    pfkp_pkg::t_phase r_phase, n_phase;
    logic [15:0] r_off, n_off;
    logic [15:0] r_etype, n_etype;
    logic [7:0]  r_nh, n_nh;
    logic [15:0] r_hstart, n_hstart;
    logic [CW-1:0] r_extcnt, n_extcnt;
    logic [31:0] r_src, n_src;
    logic [31:0] r_dst, n_dst;
    logic [16:0] r_len, n_len;
    logic [7:0]  r_flags, n_flags;
    logic [15:0] r_sport, n_sport;
    logic [15:0] r_dport, n_dport;
    logic [7:0]  r_ext_nh, n_ext_nh;
    logic [11:0] r_ext_len, n_ext_len;
    logic [1:0]  r_err, n_err;

    logic [15:0] rel;
    logic        enter_req;
    logic [7:0]  enter_nh;
    logic [8:0]  opt_units;
    logic [9:0]  ah_units;
    logic [15:0] got;
    logic [15:0] need;
    logic [1:0]  status;
    logic        is_tcp;
    logic        is_udp;

    assign rel       = (r_off >= r_hstart) ? (r_off - r_hstart) : 16'd0;
    assign opt_units = {1'b0, i_data_byte} + 9'd1;
    assign ah_units  = {2'b00, i_data_byte} + 10'd2;

    // Advance the state by one byte
    always_comb begin
        n_phase   = r_phase;
        n_etype   = r_etype;
        n_nh      = r_nh;
        n_hstart  = r_hstart;
        n_extcnt  = r_extcnt;
        n_src     = r_src;
        n_dst     = r_dst;
        n_len     = r_len;
        n_flags   = r_flags;
        n_sport   = r_sport;
        n_dport   = r_dport;
        n_ext_nh  = r_ext_nh;
        n_ext_len = r_ext_len;
        n_err     = r_err;
        enter_req = 1'b0;
        enter_nh  = r_nh;

        unique case (r_phase)
            pfkp_pkg::PH_ETH: begin
                if (r_off == 16'd12 || r_off == 16'd13) begin
                    n_etype = {r_etype[7:0], i_data_byte};
                end
                if (r_off == 16'd13) begin
                    n_hstart = pfkp_pkg::ETH_HDR_LEN;
                    if (n_etype == pfkp_pkg::ETYPE_IPV4) begin
                        n_phase = pfkp_pkg::PH_V4;
                    end else if (n_etype == pfkp_pkg::ETYPE_IPV6) begin
                        n_phase = pfkp_pkg::PH_V6;
                    end else begin
                        n_err   = pfkp_pkg::ST_NOTIP;
                        n_phase = pfkp_pkg::PH_DONE;
                    end
                end
            end
            pfkp_pkg::PH_V4: begin
                if (rel == 16'd2 || rel == 16'd3) begin
                    n_len = {r_len[8:0], i_data_byte};
                end else if (rel == 16'd9) begin
                    n_nh = i_data_byte;
                end else if (rel >= 16'd12 && rel <= 16'd15) begin
                    n_src = {r_src[23:0], i_data_byte};
                end else if (rel >= 16'd16 && rel <= 16'd19) begin
                    n_dst = {r_dst[23:0], i_data_byte};
                end
                if (rel == 16'd19) begin
                    n_hstart = pfkp_pkg::V4_L4_START;
                    n_phase  = pfkp_pkg::PH_L4;
                end
            end
            pfkp_pkg::PH_V6: begin
                if (rel == 16'd4 || rel == 16'd5) begin
                    n_len = {r_len[8:0], i_data_byte};
                end else if (rel == 16'd6) begin
                    n_nh = i_data_byte;
                end else if (rel >= 16'd8 && rel <= 16'd11) begin
                    n_src = {r_src[23:0], i_data_byte};
                end else if (rel >= 16'd24 && rel <= 16'd27) begin
                    n_dst = {r_dst[23:0], i_data_byte};
                end
                if (rel == 16'd39) begin
                    n_len     = r_len + pfkp_pkg::V6_HDR_LEN;
                    n_hstart  = pfkp_pkg::V6_L4_START;
                    enter_req = 1'b1;
                    enter_nh  = r_nh;
                end
            end
            pfkp_pkg::PH_EXT: begin
                if (rel == 16'd0) begin
                    n_ext_nh = i_data_byte;
                end else if (rel == 16'd1) begin
                    if (r_nh == pfkp_pkg::NH_FRAGMENT) begin
                        n_ext_len = pfkp_pkg::FRAG_LEN;
                    end else if (r_nh == pfkp_pkg::NH_AH) begin
                        n_ext_len = {ah_units, 2'b00};
                    end else begin
                        n_ext_len = {opt_units, 3'b000};
                    end
                end else if (r_ext_len >= 12'd2 &&
                             rel == ({4'd0, r_ext_len} - 16'd1)) begin
                    n_hstart  = r_hstart + {4'd0, r_ext_len};
                    n_nh      = r_ext_nh;
                    enter_req = 1'b1;
                    enter_nh  = r_ext_nh;
                end
            end
            pfkp_pkg::PH_L4: begin
                if (r_nh == pfkp_pkg::NH_TCP || r_nh == pfkp_pkg::NH_UDP) begin
                    if (rel <= 16'd1) begin
                        n_sport = {r_sport[7:0], i_data_byte};
                    end else if (rel <= 16'd3) begin
                        n_dport = {r_dport[7:0], i_data_byte};
                    end else if (rel == 16'd13 && r_nh == pfkp_pkg::NH_TCP) begin
                        n_flags = i_data_byte;
                    end
                end
            end
            default: begin
            end
        endcase

        // Choose skip, limit or transport for the header now starting
        if (enter_req) begin
            if (i_ext_walk && pfkp_pkg::is_ext(enter_nh)) begin
                if (r_extcnt >= EXT_MAX) begin
                    n_err   = pfkp_pkg::ST_EXTLIM;
                    n_phase = pfkp_pkg::PH_DONE;
                end else begin
                    n_extcnt  = r_extcnt + CW'(1);
                    n_ext_nh  = 8'd0;
                    n_ext_len = 12'd0;
                    n_phase   = pfkp_pkg::PH_EXT;
                end
            end else begin
                n_phase = pfkp_pkg::PH_L4;
            end
        end
    end

    // Saturating frame offset
    assign n_off = (r_off == 16'hFFFF) ? r_off : (r_off + 16'd1);

    // Status of the frame as of this byte
    assign is_tcp = (n_nh == pfkp_pkg::NH_TCP);
    assign is_udp = (n_nh == pfkp_pkg::NH_UDP);
    assign got    = (n_off >= n_hstart) ? (n_off - n_hstart) : 16'd0;
    assign need   = is_tcp ? pfkp_pkg::TCP_HDR_LEN :
                    is_udp ? pfkp_pkg::UDP_HDR_LEN : 16'd0;

    always_comb begin
        status = n_err;
        if (n_err == pfkp_pkg::ST_OK) begin
            if (n_phase != pfkp_pkg::PH_L4) begin
                status = pfkp_pkg::ST_TRUNC;
            end else if (got < need || (n_extcnt != '0 && got == 16'd0)) begin
                status = pfkp_pkg::ST_TRUNC;
            end
        end
    end

    // Form the flow key; zero every field unless the status is ok
    always_comb begin
        o_result        = '0;
        o_result.status = status;
        if (status == pfkp_pkg::ST_OK) begin
            o_result.src_address   = n_src;
            o_result.dst_address   = n_dst;
            o_result.protocol      = n_nh;
            o_result.src_port      = (is_tcp || is_udp) ? n_sport : 16'd0;
            o_result.dst_port      = (is_tcp || is_udp) ? n_dport : 16'd0;
            o_result.packet_length = n_len;
            o_result.tcp_flag_bits = is_tcp ? n_flags : 8'd0;
            o_result.l4_offset     = n_hstart;
        end
    end

    // Hold state; advance on each item, clear after the last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_last_byte)) begin
            r_phase   <= pfkp_pkg::PH_ETH;
            r_off     <= '0;
            r_etype   <= '0;
            r_nh      <= '0;
            r_hstart  <= '0;
            r_extcnt  <= '0;
            r_src     <= '0;
            r_dst     <= '0;
            r_len     <= '0;
            r_flags   <= '0;
            r_sport   <= '0;
            r_dport   <= '0;
            r_ext_nh  <= '0;
            r_ext_len <= '0;
            r_err     <= '0;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_off     <= n_off;
            r_etype   <= n_etype;
            r_nh      <= n_nh;
            r_hstart  <= n_hstart;
            r_extcnt  <= n_extcnt;
            r_src     <= n_src;
            r_dst     <= n_dst;
            r_len     <= n_len;
            r_flags   <= n_flags;
            r_sport   <= n_sport;
            r_dport   <= n_dport;
            r_ext_nh  <= n_ext_nh;
            r_ext_len <= n_ext_len;
            r_err     <= n_err;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/packet_flow_key_parser.sv -----
// ----------------------------------------------------------------------------
// packet_flow_key_parser: Ethernet / IPv4 / IPv6 flow key extractor
//
// Slave stream: one frame byte per item in i_s_tdata, starting at the
// Ethernet destination address, i_s_tlast on the final byte. Master stream:
// one flow key per frame, status in o_m_tuser, key fields in o_m_tdata.
// i_cfg_we / i_cfg_wdata write the extension-walk mode bit (reset 1);
// write it only while no frame is in progress.
//
// Throughput is one byte per cycle while o_s_tready is high: the walk updates
// its state registers in the cycle the byte is accepted, with no loop over cycles.
// The flow key is registered and appears in the cycle after the last byte is
// accepted. The output register is the only buffer, so o_s_tready drops
// only while a key waits and the receiver holds i_m_tready low; bytes of
// the next frame keep flowing while a key waits otherwise.
//
// Reset is synchronous and active low: it clears the parse state and the
// output valid, and sets the mode bit to walk extension headers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module packet_flow_key_parser #(
    parameter int MAX_EXT_HEADERS = 8
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    // mode register
    input  wire          i_cfg_we,
    input  wire          i_cfg_wdata,    // ipv6_ext_walk
    // frame byte stream
    input  wire          i_s_tvalid,
    output logic         o_s_tready,
    input  wire  [7:0]   i_s_tdata,      // [7:0] data_byte
    input  wire          i_s_tlast,      // last_byte
    // flow key stream
    output logic         o_m_tvalid,
    input  wire          i_m_tready,
    // [31:0] src_address, [63:32] dst_address, [71:64] protocol,
    // [87:72] src_port, [103:88] dst_port, [120:104] packet_length,
    // [128:121] tcp_flag_bits, [144:129] l4_offset, [151:145] zero
    output logic [151:0] o_m_tdata,
    output logic [1:0]   o_m_tuser       // [1:0] status
);

    logic              r_ext_walk;
    logic              r_valid;
    pfkp_pkg::t_result r_res;
    pfkp_pkg::t_result res;
    logic              in_accept;

    assign o_s_tready = !r_valid || i_m_tready;
    assign in_accept  = i_s_tvalid && o_s_tready;

    // Mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ext_walk <= 1'b1;
        end else if (i_cfg_we) begin
            r_ext_walk <= i_cfg_wdata;
        end
    end

    pfkp_parser #(
        .MAX_EXT_HEADERS (MAX_EXT_HEADERS)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_data_byte (i_s_tdata),
        .i_last_byte (i_s_tlast),
        .i_ext_walk  (r_ext_walk),
        .o_result    (res)
    );

    // Output register: load on the last byte, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (in_accept && i_s_tlast) begin
            r_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && i_s_tlast) begin
            r_res <= res;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tuser  = r_res.status;
    assign o_m_tdata  = {7'd0, r_res.l4_offset, r_res.tcp_flag_bits, r_res.packet_length,
                         r_res.dst_port, r_res.src_port, r_res.protocol,
                         r_res.dst_address, r_res.src_address};

endmodule

`default_nettype wire

// ----- rtl/core/pfkp_checker.sv -----
// ----------------------------------------------------------------------------
// pfkp_checker: port-level checks of the flow key parser
// Watches both streams and flags keys that appear, vanish or change wrongly.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pfkp_checker (
    input wire         i_clk,
    input wire         i_rst_n,
    input wire         i_cfg_we,
    input wire         i_cfg_wdata,
    input wire         i_s_tvalid,
    input wire         o_s_tready,
    input wire [7:0]   i_s_tdata,
    input wire         i_s_tlast,
    input wire         o_m_tvalid,
    input wire         i_m_tready,
    input wire [151:0] o_m_tdata,
    input wire [1:0]   o_m_tuser
);

    logic frame_end;
    logic out_free;

    assign frame_end = i_s_tvalid && o_s_tready && i_s_tlast;
    assign out_free  = !o_m_tvalid || i_m_tready;

    // A stalled key holds its contents
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("flow key changed while stalled");

    // Every accepted last byte yields a key in the next cycle
    a_key_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        frame_end |=> o_m_tvalid)
        else $error("no flow key after last byte");

    // No key appears without a frame end
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !frame_end && out_free |=> !o_m_tvalid)
        else $error("flow key without frame end");

    // An empty output never blocks the byte stream
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("byte stream blocked with empty output");

    // A failed parse carries an all-zero key
    a_zero_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser != pfkp_pkg::ST_OK) |-> (o_m_tdata == 152'd0))
        else $error("nonzero key with error status");

endmodule

bind packet_flow_key_parser pfkp_checker u_pfkp_checker (.*);

`default_nettype wire
